// File: rtl/bgm_pkg.sv
// bgm_pkg: constants, state codes and helper functions of the button gesture menu
package bgm_pkg;

	// configuration register and timer widths
	localparam int REG_W   = 20;
	localparam int TIMER_W = 20;
	localparam int CMP_W   = (TIMER_W > REG_W) ? TIMER_W : REG_W;
	localparam int CFG_IDX_W = 3;

	typedef logic [REG_W-1:0]   reg_val_t;
	typedef logic [TIMER_W-1:0] timer_t;
	typedef logic [3:0]         menu_state_t;
	typedef logic [1:0]         event_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MENU_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TICKS   = 3'd3;

	// register reset values
	localparam reg_val_t PRESS_TICKS_RST  = reg_val_t'(100);
	localparam reg_val_t HOLD_TICKS_RST   = reg_val_t'(2000);
	localparam reg_val_t MENU_TIMEOUT_RST = reg_val_t'(10000);
	localparam reg_val_t FLASH_TICKS_RST  = reg_val_t'(100);

	// menu state codes
	localparam menu_state_t ST_IDLE     = 4'd0;
	localparam menu_state_t ST_P1       = 4'd1;
	localparam menu_state_t ST_P2       = 4'd2;
	localparam menu_state_t ST_P3       = 4'd3;
	localparam menu_state_t ST_SHUTDOWN = 4'd4;
	localparam menu_state_t ST_P4       = 4'd5;
	localparam menu_state_t ST_P5       = 4'd6;
	localparam menu_state_t ST_P6       = 4'd7;
	localparam menu_state_t ST_P7       = 4'd8;
	localparam menu_state_t ST_CAL      = 4'd9;

	// gesture event codes
	localparam event_t EV_NONE  = 2'd0;
	localparam event_t EV_PRESS = 2'd1;
	localparam event_t EV_HOLD  = 2'd2;

	localparam timer_t TIMER_MAX = {TIMER_W{1'b1}};

	// saturating increment of a timer
	function automatic timer_t sat_inc(input timer_t v);
		sat_inc = (v == TIMER_MAX) ? v : v + timer_t'(1);
	endfunction

	// timer strictly above a register value
	function automatic logic timer_gt(input timer_t t, input reg_val_t r);
		timer_gt = CMP_W'(t) > CMP_W'(r);
	endfunction

	// led pattern shown for a menu state
	function automatic logic [3:0] leds_for(input menu_state_t s, input logic level);
		case (s)
			ST_P1:       leds_for = 4'h1;
			ST_P2:       leds_for = 4'h3;
			ST_P3:       leds_for = 4'h7;
			ST_SHUTDOWN: leds_for = 4'hF;
			ST_P4:       leds_for = 4'hF;
			ST_P5:       leds_for = 4'hE;
			ST_P6:       leds_for = 4'hC;
			ST_P7:       leds_for = 4'h8;
			ST_CAL:      leds_for = level ? 4'hF : 4'h0;
			default:     leds_for = 4'h0;
		endcase
	endfunction

	// menu transition on a gesture event
	function automatic menu_state_t next_state(input menu_state_t s, input event_t ev);
		case (s)
			ST_IDLE, ST_P1, ST_P2, ST_P5, ST_P6: begin
				next_state = (ev == EV_PRESS) ? s + menu_state_t'(1) : s;
			end
			ST_P3: begin
				next_state = (ev == EV_PRESS) ? ST_P4 : s;
			end
			ST_SHUTDOWN: begin
				next_state = (ev == EV_NONE) ? ST_IDLE : s;
			end
			ST_P4: begin
				if (ev == EV_HOLD)       next_state = ST_SHUTDOWN;
				else if (ev == EV_PRESS) next_state = ST_P5;
				else                     next_state = s;
			end
			ST_P7: begin
				if (ev == EV_HOLD)       next_state = ST_CAL;
				else if (ev == EV_PRESS) next_state = ST_IDLE;
				else                     next_state = s;
			end
			default: next_state = ST_IDLE;
		endcase
	endfunction

endpackage

// File: rtl/button_gesture_menu_fsm_core.sv
// button_gesture_menu_fsm_core: press timing, menu state machine and led output per tick
//
//   channel  signals                          moves
//   in       in_valid / in_stall              one tick request: button_down
//   out      out_valid / out_stall            one result per tick: leds and flags
//   cfg      cfg_we / cfg_index / cfg_data    register write, no wait
//
// A tick request goes into the input register, is worked on there and lands in
// the output register once it is free or being emptied: one request per cycle
// while out is not stalled. The input register is refilled while the result waits,
// so a stall on out only backs up into in_stall once both registers are full.
// Reset clears the menu state, timers and flags and loads the register defaults.
module button_gesture_menu_fsm_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// tick requests
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           button_down,
	// results
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     led_pattern,
	output logic                           menu_active,
	output logic                           in_shutdown,
	output logic                           in_calibration,
	output logic                           cal_request,
	// configuration
	input  logic                           cfg_we,
	input  logic [bgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgm_pkg::REG_W-1:0]      cfg_data
);

	// configuration registers
	bgm_pkg::reg_val_t press_ticks_q, hold_ticks_q, menu_timeout_q, flash_ticks_q;

	// input register
	logic valid_s1;
	logic button_s1;

	// block state
	bgm_pkg::menu_state_t menu_state_q;
	bgm_pkg::timer_t      press_timer_q, state_timer_q, flash_timer_q;
	logic                 press_active_q, press_counted_q, state_running_q;
	logic                 flash_level_q, cal_requested_q;

	// output register
	logic       out_valid_q;
	logic [3:0] led_q;
	logic       active_q, shutdown_q, calib_q, cal_pulse_q;

	logic advance;

	// next-state values
	bgm_pkg::menu_state_t ns_trans, ns_final;
	bgm_pkg::timer_t      ptimer_n, stimer_n, ftimer_n, ftimer_inc;
	logic                 pactive_n, pcounted_n, running_n, flevel_n, calreq_n, cal_pulse;
	bgm_pkg::event_t      ev;
	logic [3:0]           leds_n;
	logic                 timeout;

	// handshake: s1 moves on when the output register is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	assign led_pattern    = led_q;
	assign menu_active    = active_q;
	assign in_shutdown    = shutdown_q;
	assign in_calibration = calib_q;
	assign cal_request    = cal_pulse_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_ticks_q  <= bgm_pkg::PRESS_TICKS_RST;
			hold_ticks_q   <= bgm_pkg::HOLD_TICKS_RST;
			menu_timeout_q <= bgm_pkg::MENU_TIMEOUT_RST;
			flash_ticks_q  <= bgm_pkg::FLASH_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bgm_pkg::CFG_PRESS_TICKS:  press_ticks_q  <= cfg_data;
				bgm_pkg::CFG_HOLD_TICKS:   hold_ticks_q   <= cfg_data;
				bgm_pkg::CFG_MENU_TIMEOUT: menu_timeout_q <= cfg_data;
				bgm_pkg::CFG_FLASH_TICKS:  flash_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			button_s1 <= button_down;
		end
	end

	// one tick of press timing, gesture decode, flash and menu transition
	always_comb begin
		// press timer
		if (button_s1) begin
			pactive_n = 1'b1;
			if (!press_active_q) begin
				pcounted_n = 1'b0;
				ptimer_n   = '0;
			end else begin
				pcounted_n = press_counted_q;
				ptimer_n   = bgm_pkg::sat_inc(press_timer_q);
			end
		end else begin
			pactive_n  = 1'b0;
			pcounted_n = 1'b0;
			ptimer_n   = '0;
		end

		// gesture event: hold on every tick past hold time, press once per press
		ev = bgm_pkg::EV_NONE;
		if (pactive_n) begin
			if (bgm_pkg::timer_gt(ptimer_n, hold_ticks_q)) begin
				ev = bgm_pkg::EV_HOLD;
			end else if (bgm_pkg::timer_gt(ptimer_n, press_ticks_q) && !pcounted_n) begin
				ev         = bgm_pkg::EV_PRESS;
				pcounted_n = 1'b1;
			end
		end

		// flash timer runs in every state, toggles only in calibrate
		ftimer_inc = bgm_pkg::sat_inc(flash_timer_q);
		ftimer_n   = ftimer_inc;
		flevel_n   = flash_level_q;
		if (menu_state_q == bgm_pkg::ST_CAL && bgm_pkg::timer_gt(ftimer_inc, flash_ticks_q)) begin
			flevel_n = !flash_level_q;
			ftimer_n = '0;
		end
		leds_n = bgm_pkg::leds_for(menu_state_q, flevel_n);

		// menu transition and state timer
		ns_trans  = bgm_pkg::next_state(menu_state_q, ev);
		running_n = state_running_q;
		stimer_n  = state_timer_q;
		calreq_n  = cal_requested_q;
		cal_pulse = 1'b0;
		if (ns_trans != menu_state_q) begin
			stimer_n  = '0;
			running_n = 1'b1;
			if (ns_trans == bgm_pkg::ST_CAL && !cal_requested_q) begin
				calreq_n  = 1'b1;
				cal_pulse = 1'b1;
			end
		end else if (state_running_q) begin
			stimer_n = bgm_pkg::sat_inc(state_timer_q);
		end
		if (ns_trans != bgm_pkg::ST_CAL) begin
			calreq_n = 1'b0;
		end

		// menu timeout once the button is released, after flags are taken
		timeout  = running_n && bgm_pkg::timer_gt(stimer_n, menu_timeout_q) && !pactive_n;
		ns_final = ns_trans;
		if (timeout) begin
			ns_final   = bgm_pkg::ST_IDLE;
			stimer_n   = '0;
			running_n  = 1'b0;
			ptimer_n   = '0;
			pcounted_n = 1'b0;
		end
	end

	// state update on each tick that moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_state_q    <= bgm_pkg::ST_IDLE;
			press_timer_q   <= '0;
			press_active_q  <= 1'b0;
			press_counted_q <= 1'b0;
			state_timer_q   <= '0;
			state_running_q <= 1'b0;
			flash_timer_q   <= '0;
			flash_level_q   <= 1'b0;
			cal_requested_q <= 1'b0;
		end else if (advance) begin
			menu_state_q    <= ns_final;
			press_timer_q   <= ptimer_n;
			press_active_q  <= pactive_n;
			press_counted_q <= pcounted_n;
			state_timer_q   <= stimer_n;
			state_running_q <= running_n;
			flash_timer_q   <= ftimer_n;
			flash_level_q   <= flevel_n;
			cal_requested_q <= calreq_n;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, flags from the state before the timeout
	always_ff @(posedge clk) begin
		if (advance) begin
			led_q       <= leds_n;
			active_q    <= ns_trans != bgm_pkg::ST_IDLE;
			shutdown_q  <= ns_trans == bgm_pkg::ST_SHUTDOWN;
			calib_q     <= ns_trans == bgm_pkg::ST_CAL;
			cal_pulse_q <= cal_pulse;
		end
	end

endmodule

// File: sim/bgm_tick_checker.sv
// bgm_tick_checker: predicts the leds and flags of every tick and checks the core's results
module bgm_tick_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           button_down,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [3:0]                     led_pattern,
	input  logic                           menu_active,
	input  logic                           in_shutdown,
	input  logic                           in_calibration,
	input  logic                           cal_request,
	input  logic                           cfg_we,
	input  logic [bgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgm_pkg::REG_W-1:0]      cfg_data,
	output int                             failures,
	output int                             pending
);
	import bgm_pkg::*;

	typedef struct packed {
		logic [3:0] leds;
		logic       active;
		logic       shutdown;
		logic       calibrating;
		logic       cal_pulse;
	} tick_result_t;

	// results still owed by the core, oldest first
	tick_result_t tick_results_q[$];
	tick_result_t want;

	// own copy of the registers
	reg_val_t press_lim, hold_lim, timeout_lim, flash_lim;

	// own copy of the menu and its timers
	menu_state_t menu;
	timer_t      press_age, dwell_age, flash_age;
	logic        pressing, counted, dwell_on, flash_on, cal_sent;

	// timers stick at all ones
	function automatic timer_t bump(input timer_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// leds for a menu state, calibrate follows the flash level
	function automatic logic [3:0] led_code(input menu_state_t s, input logic lit);
		case (s)
			ST_P1:              return 4'b0001;
			ST_P2:              return 4'b0011;
			ST_P3:              return 4'b0111;
			ST_SHUTDOWN, ST_P4: return 4'b1111;
			ST_P5:              return 4'b1110;
			ST_P6:              return 4'b1100;
			ST_P7:              return 4'b1000;
			ST_CAL:             return {4{lit}};
			default:            return 4'b0000;
		endcase
	endfunction

	// menu step on one gesture
	function automatic menu_state_t advance_menu(input menu_state_t s, input event_t g);
		case (s)
			ST_IDLE:     return (g == EV_PRESS) ? ST_P1 : s;
			ST_P1:       return (g == EV_PRESS) ? ST_P2 : s;
			ST_P2:       return (g == EV_PRESS) ? ST_P3 : s;
			ST_P3:       return (g == EV_PRESS) ? ST_P4 : s;
			ST_P5:       return (g == EV_PRESS) ? ST_P6 : s;
			ST_P6:       return (g == EV_PRESS) ? ST_P7 : s;
			ST_SHUTDOWN: return (g == EV_NONE) ? ST_IDLE : s;
			ST_P4: begin
				if (g == EV_HOLD)
					return ST_SHUTDOWN;
				return (g == EV_PRESS) ? ST_P5 : s;
			end
			ST_P7: begin
				if (g == EV_HOLD)
					return ST_CAL;
				return (g == EV_PRESS) ? ST_IDLE : s;
			end
			default:     return ST_IDLE;
		endcase
	endfunction

	// one tick: press timing, flash, menu step, flags, then the idle timeout
	task automatic compute_tick(input logic down, output tick_result_t r);
		event_t      gesture;
		menu_state_t prior;
		logic [3:0]  shown;
		logic        pulse;
		gesture = EV_NONE;
		pulse = 1'b0;
		if (down) begin
			if (!pressing) begin
				pressing = 1'b1;
				counted = 1'b0;
				press_age = '0;
			end else begin
				press_age = bump(press_age);
			end
		end else begin
			pressing = 1'b0;
			counted = 1'b0;
			press_age = '0;
		end
		if (pressing) begin
			if (press_age > hold_lim) begin
				gesture = EV_HOLD;
			end else if (press_age > press_lim && !counted) begin
				gesture = EV_PRESS;
				counted = 1'b1;
			end
		end
		// flash timer runs in every state, toggles only in calibrate
		flash_age = bump(flash_age);
		if (menu == ST_CAL && flash_age > flash_lim) begin
			flash_on = !flash_on;
			flash_age = '0;
		end
		shown = led_code(menu, flash_on);
		prior = menu;
		menu = advance_menu(menu, gesture);
		if (menu != prior) begin
			dwell_age = '0;
			dwell_on = 1'b1;
			if (menu == ST_CAL && !cal_sent) begin
				cal_sent = 1'b1;
				pulse = 1'b1;
			end
		end else if (dwell_on) begin
			dwell_age = bump(dwell_age);
		end
		r.leds = shown;
		r.active = (menu != ST_IDLE);
		r.shutdown = (menu == ST_SHUTDOWN);
		r.calibrating = (menu == ST_CAL);
		r.cal_pulse = pulse;
		if (menu != ST_CAL)
			cal_sent = 1'b0;
		// timeout back to idle once released, after the flags were taken
		if (dwell_on && dwell_age > timeout_lim && !pressing) begin
			menu = ST_IDLE;
			dwell_age = '0;
			dwell_on = 1'b0;
			press_age = '0;
			counted = 1'b0;
		end
	endtask

	// watch register writes, tick requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_results_q.delete();
			press_lim = PRESS_TICKS_RST;
			hold_lim = HOLD_TICKS_RST;
			timeout_lim = MENU_TIMEOUT_RST;
			flash_lim = FLASH_TICKS_RST;
			menu = ST_IDLE;
			press_age = '0;
			dwell_age = '0;
			flash_age = '0;
			pressing = 1'b0;
			counted = 1'b0;
			dwell_on = 1'b0;
			flash_on = 1'b0;
			cal_sent = 1'b0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRESS_TICKS:  press_lim = cfg_data;
					CFG_HOLD_TICKS:   hold_lim = cfg_data;
					CFG_MENU_TIMEOUT: timeout_lim = cfg_data;
					CFG_FLASH_TICKS:  flash_lim = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				compute_tick(button_down, want);
				tick_results_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (tick_results_q.size() == 0) begin
					if (failures < 10)
						$display("unexpected result: leds %h active %b shutdown %b cal %b req %b",
							led_pattern, menu_active, in_shutdown, in_calibration, cal_request);
					failures <= failures + 1;
				end else begin
					want = tick_results_q.pop_front();
					if (want.leds !== led_pattern || want.active !== menu_active ||
						want.shutdown !== in_shutdown || want.calibrating !== in_calibration ||
						want.cal_pulse !== cal_request) begin
						if (failures < 10)
							$display({"mismatch (expected/actual): leds %h/%h active %b/%b",
								" shutdown %b/%b cal %b/%b req %b/%b"},
								want.leds, led_pattern, want.active, menu_active,
								want.shutdown, in_shutdown, want.calibrating, in_calibration,
								want.cal_pulse, cal_request);
						failures <= failures + 1;
					end
				end
			end
			pending <= tick_results_q.size();
		end
	end

endmodule

// File: sim/tb.sv
// tb: reset, tick stimulus, register settings and verdict for the button gesture menu core
module tb;
	import bgm_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int LEN_CAP = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_BASE = CFG_FLASH_TICKS + 3'd1;
	localparam reg_val_t REG_MAX = {REG_W{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 button_down = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [3:0]           led_pattern;
	logic                 menu_active;
	logic                 in_shutdown;
	logic                 in_calibration;
	logic                 cal_request;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	reg_val_t             cfg_data = '0;
	int                   failures;
	int                   pending;

	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	int   stall_left = 0;
	int   rx_draw;
	int   quiet_cycles = 0;
	int   phase_ticks = 0;
	int   press_cfg, hold_cfg, timeout_cfg;

	always #6 clk = ~clk;

	button_gesture_menu_fsm_core dut (.*);

	bgm_tick_checker watch (.*);

	// wait drawn per request or result, with calm stretches of none
	function automatic int gap_draw(input logic calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return $urandom_range(0, 2);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	function automatic int clip(input int n);
		return (n > LEN_CAP) ? LEN_CAP : n;
	endfunction

	// result side: hold out_stall after each accepted result for a wait from gap_draw
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			rx_draw = gap_draw(rx_calm);
			stall_left <= rx_draw;
			out_stall <= (rx_draw != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no request and no result moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one tick request, valid kept high when the next follows at once
	task automatic send_tick(input logic level);
		int gap;
		gap = gap_draw(tx_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_down <= level;
		do @(posedge clk); while (in_stall);
		phase_ticks++;
	endtask

	task automatic repeat_tick(input logic level, input int count);
		repeat (count) send_tick(level);
	endtask

	// stop requesting and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// all four registers, then a write to an unused index
	task automatic configure(input int p, input int h, input int t, input int f);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRESS_TICKS;
		cfg_data <= reg_val_t'(p);
		@(posedge clk);
		cfg_index <= CFG_HOLD_TICKS;
		cfg_data <= reg_val_t'(h);
		@(posedge clk);
		cfg_index <= CFG_MENU_TIMEOUT;
		cfg_data <= reg_val_t'(t);
		@(posedge clk);
		cfg_index <= CFG_FLASH_TICKS;
		cfg_data <= reg_val_t'(f);
		@(posedge clk);
		cfg_index <= CFG_SPARE_BASE + CFG_IDX_W'($urandom_range(0, 3));
		cfg_data <= reg_val_t'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		press_cfg = p;
		hold_cfg = h;
		timeout_cfg = t;
	endtask

	// a run of presses, most long enough to count, the last one maybe held, then a release
	task automatic press_run(input int presses, input logic close_hold);
		int held;
		for (int i = 1; i <= presses; i++) begin
			if (close_hold && i == presses)
				held = hold_cfg + 2 + $urandom_range(0, 3);
			else if ($urandom_range(0, 7) == 0)
				held = press_cfg + 1;
			else
				held = press_cfg + 2 + $urandom_range(0, 2);
			repeat_tick(1'b1, clip(held));
			if (i == presses)
				repeat_tick(1'b0, $urandom_range(1, clip(timeout_cfg + 3)));
			else
				repeat_tick(1'b0, $urandom_range(1, 3));
		end
	endtask

	initial begin
		int pk, hk, presses;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight after reset: short presses never count
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();

		// zero press time: six quick presses, a seventh held into calibrate, flash every tick
		configure(0, 2, 20, 0);
		repeat (6) begin
			repeat_tick(1'b1, 2);
			send_tick(1'b0);
		end
		repeat_tick(1'b1, 4);
		repeat_tick(1'b0, 2);

		// random phases, each with its own register setting
		for (int p = 0; p < 10; p++) begin
			drain();
			case (p)
				3: configure(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
				6: configure(0, 0, 0, 0);
				default: begin
					pk = $urandom_range(0, 4);
					hk = (p == 8) ? $urandom_range(0, pk) : pk + $urandom_range(1, 7);
					configure(pk, hk, $urandom_range(1, 40), $urandom_range(0, 6));
				end
			endcase
			phase_ticks = 0;
			while (phase_ticks < ((p == 3 || p == 6) ? 50 : 150)) begin
				tx_calm = ($urandom_range(0, 4) == 0);
				rx_calm = ($urandom_range(0, 4) == 0);
				case ($urandom_range(0, 9))
					7, 8: repeat ($urandom_range(1, 12)) send_tick($urandom_range(0, 1) != 0);
					9: repeat_tick(1'b0, clip(timeout_cfg + 2 + $urandom_range(0, 2)));
					default: begin
						case ($urandom_range(0, 5))
							0:       presses = 4;
							1:       presses = 7;
							2:       presses = 8;
							default: presses = $urandom_range(1, 8);
						endcase
						press_run(presses, $urandom_range(0, 2) == 0);
					end
				endcase
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bgm_pkg.sv
rtl/button_gesture_menu_fsm_core.sv
sim/bgm_tick_checker.sv
sim/tb.sv
